/* src/hfau_pkg.sv */
// Package for the half-precision arithmetic unit: opcodes and widths.
// Used by the top level and the arithmetic core.
package hfau_pkg;
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_I2H = 3'd4;
  localparam logic [2:0] OP_H2I = 3'd5;
  localparam logic [15:0] NAN_OUT = 16'h7FFF;
  localparam logic [14:0] EXP_ONES = 15'h7C00;
  localparam int QUO_BITS = 24;
endpackage

/* src/hfau_core.sv */
// Pipelined arithmetic core of the half-precision unit.
// Depends on hfau_pkg. Stage advance is controlled by en from the top level.
module hfau_core
  import hfau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [2:0]  op_in,
  input  logic [15:0] a_in,
  input  logic [15:0] b_in,
  output logic        out_valid,
  output logic [15:0] res_out
);
  // Stage 0: decode and special cases.
  logic [1:0] vld;
  logic [2:0] op0;
  logic [15:0] a0, b0;
  logic done0;
  logic [15:0] r0;
  logic [10:0] ma0, mb0;
  logic signed [7:0] e0;

  logic [15:0] ain, bin;
  logic za, zb, ba, bb;
  logic [10:0] mai, mbi;
  logic [5:0] eaa, eba;
  always_comb begin
    ain = a_in;
    bin = (op_in == OP_SUB) ? (b_in ^ 16'h8000) : b_in;
    za = ain[14:0] == 15'd0;
    zb = bin[14:0] == 15'd0;
    ba = ain[14:10] == 5'h1F;
    bb = bin[14:10] == 5'h1F;
    mai = {ain[14:10] != 5'd0, ain[9:0]};
    mbi = {bin[14:10] != 5'd0, bin[9:0]};
    eaa = (ain[14:10] == 5'd0) ? 6'd1 : {1'b0, ain[14:10]};
    eba = (bin[14:10] == 5'd0) ? 6'd1 : {1'b0, bin[14:10]};
  end

  logic d_done;
  logic [15:0] d_r;
  always_comb begin
    d_done = 1'b1;
    d_r = 16'd0;
    case (op_in)
      OP_ADD, OP_SUB: begin
        if (za) d_r = zb ? 16'd0 : bin;
        else if (zb) d_r = ain;
        else if (ba || bb) d_r = NAN_OUT;
        else d_done = 1'b0;
      end
      OP_MUL: begin
        if (ba || bb) d_r = NAN_OUT;
        else if (za || zb) d_r = 16'd0;
        else d_done = 1'b0;
      end
      OP_DIV: begin
        if (ba || bb || (za && zb)) d_r = NAN_OUT;
        else if (zb) d_r = {ain[15] ^ bin[15], EXP_ONES};
        else if (za) d_r = 16'd0;
        else d_done = 1'b0;
      end
      OP_I2H: begin
        if (ain == 16'd0) d_r = 16'd0;
        else d_done = 1'b0;
      end
      OP_H2I: d_done = 1'b0;
      default: d_r = 16'd0;
    endcase
  end

  // Stage 1 state: swapped operands / multiplier operands / dividend.
  logic [2:0] op1;
  logic done1;
  logic [15:0] r1;
  logic sg1;
  logic signed [7:0] e1;
  logic [10:0] m1a, m1b;
  logic [5:0] dif1;
  logic [15:0] ai1;
  logic [23:0] num1;

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
    if (en) begin
      op0 <= op_in; a0 <= ain; b0 <= bin; done0 <= d_done; r0 <= d_r;
      ma0 <= mai; mb0 <= mbi;
      e0 <= $signed({2'b0, eaa}) - $signed({2'b0, eba});
    end
  end

  // Stage 1: operand ordering for add; dividend setup for divide.
  logic swp;
  logic [10:0] ma_s, mb_s;
  logic [15:0] hi_s;
  logic [5:0] ea_s, eb_s;
  always_comb begin
    swp = a0[14:0] < b0[14:0];
    hi_s = swp ? b0 : a0;
    ma_s = swp ? mb0 : ma0;
    mb_s = swp ? ma0 : mb0;
    ea_s = (hi_s[14:10] == 5'd0) ? 6'd1 : {1'b0, hi_s[14:10]};
    eb_s = ((swp ? a0[14:10] : b0[14:10]) == 5'd0) ? 6'd1
           : {1'b0, (swp ? a0[14:10] : b0[14:10])};
  end

  always_ff @(posedge clk) begin
    if (rst) vld[1] <= 1'b0;
    else if (en) vld[1] <= vld[0];
    if (en) begin
      op1 <= op0; done1 <= done0; r1 <= r0; ai1 <= a0;
      case (op0)
        OP_ADD, OP_SUB: begin
          sg1 <= (a0[15] != b0[15] && swp) ? ~a0[15] : a0[15];
          m1a <= ma_s; m1b <= mb_s; dif1 <= ea_s - eb_s;
          e1 <= {3'b0, hi_s[14:10]};
        end
        default: begin
          sg1 <= a0[15] ^ b0[15];
          m1a <= ma0; m1b <= mb0;
          dif1 <= 6'd0;
          e1 <= (op0 == OP_MUL)
                ? $signed({2'b0, ((a0[14:10] == 5'd0) ? 6'd1 : {1'b0, a0[14:10]})})
                  + $signed({2'b0, ((b0[14:10] == 5'd0) ? 6'd1 : {1'b0, b0[14:10]})})
                  - 8'sd15
                : e0 + 8'sd15;
        end
      endcase
      num1 <= {ma0, 13'd0} + {14'd0, mb0[10:1]};
    end
  end

  // Sign equality of the add is carried through a dedicated register.
  logic same_q1;
  always_ff @(posedge clk) begin
    if (en) same_q1 <= ~(a0[15] ^ b0[15]);
  end

  // Stage 2: add/sub core, product, or divide start.
  logic [11:0] addv;
  logic [15:0] subv;
  logic [11:0] m2sh;
  always_comb begin
    m2sh = (dif1 >= 6'd32) ? 12'd0 : ({1'b0, m1b} >> dif1);
    addv = {1'b0, m1a} + m2sh;
    subv = {4'd0, m1a, 1'b0} -
           ((dif1 >= 6'd32) ? 16'd0 : ({4'd0, m1b, 1'b0} >> dif1));
  end

  // Divider: restoring, one quotient bit per stage. Entry 0 is the stage 2 register.
  localparam int DQ = QUO_BITS;
  logic [DQ:0] dvld;
  logic [2:0] dop [DQ+1];
  logic ddone [DQ+1];
  logic [15:0] dr [DQ+1];
  logic dsg [DQ+1];
  logic signed [7:0] de [DQ+1];
  logic [21:0] dv [DQ+1];
  logic [11:0] same_add [DQ+1];
  logic dsame [DQ+1];
  logic [15:0] dai [DQ+1];
  logic [11:0] drem [DQ+1];
  logic [23:0] dnum [DQ+1];
  logic [DQ-1:0] dquo [DQ+1];
  logic [10:0] dden [DQ+1];

  always_ff @(posedge clk) begin
    if (rst) dvld[0] <= 1'b0;
    else if (en) dvld[0] <= vld[1];
    if (en) begin
      dop[0] <= op1; ddone[0] <= done1; dr[0] <= r1; dsg[0] <= sg1; de[0] <= e1;
      dai[0] <= ai1; dden[0] <= m1b; dnum[0] <= num1;
      same_add[0] <= addv; dsame[0] <= same_q1;
      drem[0] <= 12'd0; dquo[0] <= '0;
      case (op1)
        OP_ADD, OP_SUB: dv[0] <= {6'd0, subv};
        OP_MUL: dv[0] <= {11'd0, m1a} * {11'd0, m1b};
        default: dv[0] <= 22'd0;
      endcase
    end
  end

  for (genvar k = 0; k < DQ; k++) begin : g_div
    logic [12:0] t;
    logic [11:0] rm;
    assign t = {drem[k], dnum[k][DQ-1-k]};
    assign rm = t[11:0];
    always_ff @(posedge clk) begin
      if (rst) dvld[k+1] <= 1'b0;
      else if (en) dvld[k+1] <= dvld[k];
      if (en) begin
        dop[k+1] <= dop[k]; ddone[k+1] <= ddone[k]; dr[k+1] <= dr[k];
        dsg[k+1] <= dsg[k]; de[k+1] <= de[k]; dv[k+1] <= dv[k];
        same_add[k+1] <= same_add[k]; dsame[k+1] <= dsame[k]; dai[k+1] <= dai[k];
        dnum[k+1] <= dnum[k]; dden[k+1] <= dden[k];
        if (t >= {2'b0, dden[k]}) begin
          drem[k+1] <= 12'(t - {2'b0, dden[k]});
          dquo[k+1] <= {dquo[k][DQ-2:0], 1'b1};
        end else begin
          drem[k+1] <= rm;
          dquo[k+1] <= {dquo[k][DQ-2:0], 1'b0};
        end
      end
    end
  end

  // Final stage: normalization and packing for every operation.
  function automatic logic [4:0] lzc16(input logic [15:0] x);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 0; i < 16; i++) if (x[i]) n = 5'(15 - i);
    return n;
  endfunction
  function automatic logic [4:0] lzc24(input logic [23:0] x);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) if (x[i]) n = 5'(23 - i);
    return n;
  endfunction

  logic [2:0] fo;
  logic fd, fs, fsame;
  logic [15:0] fr, fa;
  logic signed [7:0] fe;
  logic [21:0] fv;
  logic [11:0] fadd;
  logic [23:0] fq;
  assign fo = dop[DQ]; assign fd = ddone[DQ]; assign fr = dr[DQ];
  assign fs = dsg[DQ]; assign fe = de[DQ]; assign fv = dv[DQ];
  assign fadd = same_add[DQ]; assign fsame = dsame[DQ]; assign fa = dai[DQ];
  assign fq = dquo[DQ];

  logic [15:0] res_c;
  always_comb begin
    logic signed [9:0] e;
    logic [23:0] v;
    logic [15:0] m;
    logic [4:0] lz;
    logic [16:0] iv;
    logic signed [6:0] s;
    e = 10'(fe); v = '0; m = '0; lz = '0; iv = '0; s = '0;
    res_c = 16'd0;
    case (fo)
      OP_ADD, OP_SUB: begin
        if (fsame) begin
          m = {4'd0, fadd};
          if (fadd[11]) begin m = m >> 1; e = e + 10'sd1; end
          if (e == 0 && m[10]) e = 10'sd1;
        end else begin
          m = fv[15:0];
          lz = lzc16({m[11:0], 4'hF} & 16'hFFF0);
          // Shift up to bring the top bit to position 11, limited by the exponent.
          // A zero difference always runs the exponent down to zero.
          if (m[11]) ;
          else if (m != 16'd0 && e > 10'(lz)) begin
            m = (m << lz) & 16'hFFFF; e = e - 10'(lz);
          end else if (e > 0) begin
            m = (m << (e - 10'sd1)) & 16'hFFFF; e = 10'sd0;
          end
          m = m >> 1;
        end
        if (e >= 10'sd31) res_c = {fs, EXP_ONES};
        else res_c = {fs, e[4:0], m[9:0]};
      end
      OP_MUL: begin
        v = {2'd0, fv};
        if (fv[21]) begin v = v >> 11; e = e + 10'sd1; end
        else if (fv[20]) v = v >> 10;
        else begin
          e = e - 10'sd10;
          lz = lzc24(v);
          if (v >= 24'd2048) begin
            v = v >> (5'd13 - lz); e = e + 10'(5'd13 - lz);
          end
        end
        if (e <= 0) begin
          v = ((10'sd1 - e) >= 10'sd32) ? 24'd0 : v >> (10'sd1 - e); e = 0;
          res_c = {fs, 5'd0, v[9:0]};
        end else if (e >= 10'sd31) res_c = {fs, EXP_ONES};
        else res_c = {fs, e[4:0], v[9:0]};
      end
      OP_DIV: begin
        v = fq;
        if (v != 0) begin
          lz = lzc24(v);
          // v < 8192 means lz > 10
          if (lz > 5'd10) begin
            if (e > $signed(10'(lz - 5'd10))) begin
              v = v << (lz - 5'd10); e = e - 10'(lz - 5'd10);
            end else if (e > 0) begin
              v = v << e; e = 0;
            end
          end else if (lz < 5'd10) begin
            v = v >> (5'd10 - lz); e = e + 10'(5'd10 - lz);
          end
          if (e <= 0) begin
            v = ((10'sd1 - e) >= 10'sd32) ? 24'd0 : v >> (10'sd1 - e); e = 0;
            v = v >> 3;
            res_c = {fs, 5'd0, v[9:0]};
          end else if (e >= 10'sd31) res_c = {fs, EXP_ONES};
          else begin v = v >> 3; res_c = {fs, e[4:0], v[9:0]}; end
        end
      end
      OP_I2H: begin
        iv = fa[15] ? 17'(17'h10000 - {1'b0, fa}) : {1'b0, fa};
        lz = lzc24({7'd0, iv});
        // The leading one lands on bit 10, so the exponent is 15 plus its position.
        e = 10'sd38 - 10'(lz);
        if (lz < 5'd13) iv = iv >> (5'd13 - lz);
        else iv = iv << (lz - 5'd13);
        if (e >= 10'sd31) res_c = {fa[15], EXP_ONES};
        else res_c = {fa[15], e[4:0], iv[9:0]};
      end
      OP_H2I: begin
        m = {5'd0, fa[14:10] != 5'd0, fa[9:0]};
        s = 7'({2'b0, fa[14:10]}) - 7'sd25;
        if (s > 0) m = m << s[2:0];
        else if (s < 0) m = m >> (-s);
        if (fa[15]) m = 16'(17'h10000 - {1'b0, m});
        res_c = m;
      end
      default: res_c = 16'd0;
    endcase
    if (fd) res_c = fr;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dvld[DQ];
    if (en) res_out <= res_c;
  end
endmodule

/* src/half_float_arith_unit.sv */
// Half-precision arithmetic unit: add, sub, mul, div and int16 conversions.
// Top level; depends on hfau_pkg and hfau_core.
// One request per cycle while the output is not stalled; the path from the accepting edge to
// the result runs through three front stages, the 24 one-bit-per-stage divider stages that every
// request passes through, and the output register.
// The whole pipeline holds while the output is stalled.
module half_float_arith_unit
  import hfau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // req_type[2:0], operand_a[18:3], operand_b[34:19]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // result[15:0]
);
  logic en;
  assign en = m_tready || !m_tvalid;
  assign s_tready = en && !rst;

  hfau_core u_core (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .op_in(s_tdata[2:0]), .a_in(s_tdata[18:3]), .b_in(s_tdata[34:19]),
    .out_valid(m_tvalid), .res_out(m_tdata)
  );
endmodule
